[hdl/svn_pkg.sv]
`default_nettype none

package svn_pkg;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // normalization modes
  localparam logic [1:0] MODE_STATE  = 2'd0;
  localparam logic [1:0] MODE_TRACE  = 2'd1;
  localparam logic [1:0] MODE_COLUMN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  localparam int MODE_W     = 2;
  localparam int RCNT_W     = 13;
  localparam int CCNT_W     = 7;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 64;
  localparam int TRACE_W    = 64;
  localparam int DIVR_W     = 64;
  localparam int ADDR_FULL_W = COL_W + RCNT_W + 1;

  typedef struct packed {
    logic capture;
    logic addr_calc;
    logic load_write;
    logic decide;
    logic sqrt_step;
    logic sqrt_end;
    logic div_init;
    logic div_step;
    logic div_save;
    logic div_sel_im;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_fetch;
    logic need_sqrt;
    logic do_div;
    logic root_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hdl/state_vector_normalizer.sv]
`default_nettype none

// Complex state normalizer.
// Input channel (in_valid_i / in_stall_o): operation_i selects a load, which
// writes one element at column*row_count+row and updates the column square
// sum and, on the diagonal, the trace, or a fetch, which returns the element
// normalized by the column-0 norm (column 0 only), its own column norm or the
// real trace (diagonal only). A load gives no output item, a fetch exactly one.
// Output channel (out_valid_o / out_stall_i): one registered result item. A
// new input item is taken while a result still waits; a fetch only finishes
// once the output register is free, so a stalling receiver holds the block.
// A load passes through address calculation and the store write. A fetch
// reads the store and decides; when it divides, it runs the shared bit-serial
// divider on the real and then the imaginary part, after the bit-serial square
// root the first time a column norm is needed after loading.
// The user must write configuration (cfg_we_i, cfg_index_i, cfg_data_i) only while idle; the block does not enforce it.
// Reset clears all sums, cached norms and the trace at once (valid bits);
// the element store holds no reset value.
module state_vector_normalizer #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_COLUMNS = 64,
  parameter int ELEM_WIDTH  = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [svn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [svn_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic                              operation_i,
  input  wire logic [svn_pkg::ROW_W-1:0]         row_index_i,
  input  wire logic [svn_pkg::COL_W-1:0]         column_index_i,
  input  wire logic signed [ELEM_WIDTH-1:0]      elem_real_i,
  input  wire logic signed [ELEM_WIDTH-1:0]      elem_imag_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic signed [ELEM_WIDTH-1:0]      out_real_o,
  output      logic signed [ELEM_WIDTH-1:0]      out_imag_o,
  output      logic                              bad_divisor_o
);

  import svn_pkg::*;

  // root of sum * 2^FRAC takes one step per result bit
  localparam int SQRT_STEPS = (SUM_W + ELEM_WIDTH - 2 + 1) / 2;
  // dividend |x| * 2^FRAC, one quotient bit per step
  localparam int DIV_STEPS  = 2 * ELEM_WIDTH - 2;

  logic [MODE_W-1:0] mode_q;
  logic [RCNT_W-1:0] rows_q;
  logic [CCNT_W-1:0] cols_q;

  // config registers; unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STATE;
      rows_q <= RCNT_W'(1);
      cols_q <= CCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_ROWS: rows_q <= cfg_data_i[RCNT_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[CCNT_W-1:0];
        default:  mode_q <= mode_q;
      endcase
    end
  end

  cmd_t    cmd;
  status_t st;

  svn_ctrl #(.SQRT_STEPS(SQRT_STEPS), .DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .st_i(st), .cmd_o(cmd)
  );

  svn_dp #(
    .STORE_DEPTH(STORE_DEPTH), .MAX_COLUMNS(MAX_COLUMNS), .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni,
    .mode_i(mode_q), .rows_i(rows_q), .cols_i(cols_q),
    .operation_i, .row_index_i, .column_index_i, .elem_real_i, .elem_imag_i,
    .cmd_i(cmd), .st_o(st),
    .out_valid_o, .out_stall_i, .out_real_o, .out_imag_o, .bad_divisor_o
  );

endmodule

`default_nettype wire

[hdl/svn_ram.sv]
`default_nettype none

module svn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/svn_dp.sv]
`default_nettype none

module svn_dp #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_COLUMNS = 64,
  parameter int ELEM_WIDTH  = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [svn_pkg::MODE_W-1:0]       mode_i,
  input  wire logic [svn_pkg::RCNT_W-1:0]       rows_i,
  input  wire logic [svn_pkg::CCNT_W-1:0]       cols_i,
  input  wire logic                             operation_i,
  input  wire logic [svn_pkg::ROW_W-1:0]        row_index_i,
  input  wire logic [svn_pkg::COL_W-1:0]        column_index_i,
  input  wire logic signed [ELEM_WIDTH-1:0]     elem_real_i,
  input  wire logic signed [ELEM_WIDTH-1:0]     elem_imag_i,
  input  wire svn_pkg::cmd_t                    cmd_i,
  output      svn_pkg::status_t                 st_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic signed [ELEM_WIDTH-1:0]     out_real_o,
  output      logic signed [ELEM_WIDTH-1:0]     out_imag_o,
  output      logic                             bad_divisor_o
);

  import svn_pkg::*;

  localparam int W    = ELEM_WIDTH;
  localparam int FRAC = W - 2;
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NW   = SUM_W + FRAC;
  localparam int RW   = (NW + 1) / 2;
  localparam int NPAD = 2 * RW;
  localparam int RMW  = RW + 2;
  localparam int NDW  = 2 * W - 2;
  localparam logic [NDW-1:0] LIM_POS = {{(NDW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NDW-1:0] LIM_NEG = LIM_POS + 1'b1;

  // captured item
  logic                 op_q;
  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic [W-1:0]         in_re_q, in_im_q;

  logic [AW-1:0]        addr_q;
  logic                 ok_q;
  logic [SUM_W-1:0]     sq_q;

  logic                 fetching_q;
  logic [MAX_COLUMNS-1:0] sum_valid_q, norm_valid_q;
  logic [TRACE_W-1:0]   trace_q;

  logic [W-1:0]         re_q, im_q;
  logic [DIVR_W-1:0]    d_q;
  logic [W-1:0]         res_re_q, res_im_q;
  logic                 bad_q;

  logic [NPAD-1:0]      nshift_q;
  logic [RMW-1:0]       srem_q;
  logic [RW-1:0]        root_q;

  logic [NDW-1:0]       dvd_q, quo_q;
  logic [DIVR_W-1:0]    drem_q;

  logic                 out_valid_q;
  logic [W-1:0]         out_re_q, out_im_q;
  logic                 out_bad_q;

  // address and squared magnitude
  logic [ADDR_FULL_W-1:0] addr_full;
  logic                   ok_now;
  logic [W-1:0]           mag_a, mag_b;
  logic [2*W-1:0]         prod_a, prod_b;
  logic [2*W:0]           prod_sum;

  always_comb begin
    addr_full = ADDR_FULL_W'(col_q) * ADDR_FULL_W'(rows_i) + ADDR_FULL_W'(row_q);
    ok_now = ({1'b0, row_q} < rows_i) && ({1'b0, col_q} < cols_i) &&
             (col_q < MAX_COLUMNS) && (addr_full < STORE_DEPTH);
    mag_a = in_re_q[W-1] ? (~in_re_q + 1'b1) : in_re_q;
    mag_b = in_im_q[W-1] ? (~in_im_q + 1'b1) : in_im_q;
    prod_a = (2*W)'({{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_a});
    prod_b = (2*W)'({{W{1'b0}}, mag_b} * {{W{1'b0}}, mag_b});
    prod_sum = {1'b0, prod_a} + {1'b0, prod_b};
  end

  // column select for sums and norms
  logic [CW-1:0] col_idx, rd_col;
  logic          diag;
  assign col_idx = CW'(col_q);
  assign rd_col  = (op_q == OP_FETCH && mode_i == MODE_STATE) ? '0 : col_idx;
  assign diag    = (row_q == {{(ROW_W-COL_W){1'b0}}, col_q});

  logic [W-1:0]     st_re_rd, st_im_rd;
  logic [SUM_W-1:0] sum_rd;
  logic [RW-1:0]    norm_rd;
  logic             store_we;

  assign store_we = cmd_i.load_write && ok_q;

  svn_ram #(.WIDTH(W), .DEPTH(STORE_DEPTH)) u_store_re (
    .clk_i, .we_i(store_we), .waddr_i(addr_q), .wdata_i(in_re_q),
    .raddr_i(addr_q), .rdata_o(st_re_rd)
  );

  svn_ram #(.WIDTH(W), .DEPTH(STORE_DEPTH)) u_store_im (
    .clk_i, .we_i(store_we), .waddr_i(addr_q), .wdata_i(in_im_q),
    .raddr_i(addr_q), .rdata_o(st_im_rd)
  );

  // saturating column sum
  logic [SUM_W-1:0] sum_old;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  assign sum_old = sum_valid_q[col_idx] ? sum_rd : '0;
  assign sum_add = {1'b0, sum_old} + {1'b0, sq_q};
  assign sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  svn_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLUMNS)) u_sums (
    .clk_i, .we_i(store_we), .waddr_i(col_idx), .wdata_i(sum_new),
    .raddr_i(rd_col), .rdata_o(sum_rd)
  );

  svn_ram #(.WIDTH(RW), .DEPTH(MAX_COLUMNS)) u_norms (
    .clk_i, .we_i(cmd_i.sqrt_end), .waddr_i(rd_col), .wdata_i(root_q),
    .raddr_i(rd_col), .rdata_o(norm_rd)
  );

  // saturating trace
  logic [TRACE_W:0]   tr_add;
  logic [TRACE_W-1:0] tr_new;
  always_comb begin
    tr_add = {trace_q[TRACE_W-1], trace_q} +
             {{(TRACE_W+1-W){in_re_q[W-1]}}, in_re_q};
    if (tr_add[TRACE_W] != tr_add[TRACE_W-1]) begin
      tr_new = tr_add[TRACE_W] ? {1'b1, {(TRACE_W-1){1'b0}}}
                               : {1'b0, {(TRACE_W-1){1'b1}}};
    end else begin
      tr_new = tr_add[TRACE_W-1:0];
    end
  end

  // decision on a fetch
  logic              div_norm, div_tr, need_sqrt, bad_now, do_div;
  logic [DIVR_W-1:0] dval;
  always_comb begin
    div_norm  = ok_q && ((mode_i == MODE_STATE && col_q == '0) ||
                         mode_i == MODE_COLUMN);
    div_tr    = ok_q && mode_i == MODE_TRACE && diag;
    need_sqrt = div_norm && !norm_valid_q[rd_col];
    dval      = div_norm ? DIVR_W'(norm_rd)
                         : (trace_q[TRACE_W-1] ? '0 : DIVR_W'(trace_q));
    bad_now   = ((div_norm && !need_sqrt) || div_tr) && (dval == '0);
    do_div    = ((div_norm && !need_sqrt) || div_tr) && (dval != '0);
  end

  // square root step
  logic [RMW+1:0] s_sh, s_trial;
  logic           s_ge;
  assign s_sh    = {srem_q, nshift_q[NPAD-1 -: 2]};
  assign s_trial = (RMW+2)'({root_q, 2'b01});
  assign s_ge    = (s_sh >= s_trial);

  // divide step and final saturation
  logic [W-1:0]      d_op, d_mag;
  logic              d_neg;
  logic [DIVR_W:0]   d_sh;
  logic              d_ge;
  logic [NDW-1:0]    d_lim, d_qs;
  logic [W-1:0]      d_res;
  always_comb begin
    d_op  = cmd_i.div_sel_im ? im_q : re_q;
    d_neg = d_op[W-1];
    d_mag = d_neg ? (~d_op + 1'b1) : d_op;
    d_sh  = {drem_q, dvd_q[NDW-1]};
    d_ge  = (d_sh >= {1'b0, d_q});
    d_lim = d_neg ? LIM_NEG : LIM_POS;
    d_qs  = (quo_q > d_lim) ? d_lim : quo_q;
    d_res = d_neg ? (~W'(d_qs) + 1'b1) : W'(d_qs);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetching_q   <= 1'b0;
      sum_valid_q  <= '0;
      norm_valid_q <= '0;
      trace_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        if (operation_i == OP_FETCH) begin
          fetching_q <= 1'b1;
        end else if (fetching_q) begin
          fetching_q   <= 1'b0;
          sum_valid_q  <= '0;
          norm_valid_q <= '0;
          trace_q      <= '0;
        end
      end
      if (store_we) begin
        sum_valid_q[col_idx] <= 1'b1;
        if (diag) begin
          trace_q <= tr_new;
        end
      end
      if (cmd_i.sqrt_end) begin
        norm_valid_q[rd_col] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      row_q   <= row_index_i;
      col_q   <= column_index_i;
      in_re_q <= elem_real_i;
      in_im_q <= elem_imag_i;
    end
    if (cmd_i.addr_calc) begin
      addr_q <= AW'(addr_full);
      ok_q   <= ok_now;
      sq_q   <= SUM_W'(prod_sum >> FRAC);
    end
    if (cmd_i.decide) begin
      re_q     <= st_re_rd;
      im_q     <= st_im_rd;
      d_q      <= dval;
      res_re_q <= ok_q ? st_re_rd : '0;
      res_im_q <= ok_q ? st_im_rd : '0;
      bad_q    <= bad_now;
      nshift_q <= NPAD'({sum_valid_q[rd_col] ? sum_rd : '0, {FRAC{1'b0}}});
      srem_q   <= '0;
      root_q   <= '0;
    end
    if (cmd_i.sqrt_step) begin
      srem_q   <= s_ge ? RMW'(s_sh - s_trial) : RMW'(s_sh);
      root_q   <= {root_q[RW-2:0], s_ge};
      nshift_q <= {nshift_q[NPAD-3:0], 2'b00};
    end
    if (cmd_i.sqrt_end) begin
      d_q   <= DIVR_W'(root_q);
      bad_q <= (root_q == '0);
    end
    if (cmd_i.div_init) begin
      dvd_q  <= {d_mag, {FRAC{1'b0}}};
      quo_q  <= '0;
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      drem_q <= d_ge ? DIVR_W'(d_sh - {1'b0, d_q}) : DIVR_W'(d_sh);
      quo_q  <= {quo_q[NDW-2:0], d_ge};
      dvd_q  <= {dvd_q[NDW-2:0], 1'b0};
    end
    if (cmd_i.div_save) begin
      if (cmd_i.div_sel_im) begin
        res_im_q <= d_res;
      end else begin
        res_re_q <= d_res;
      end
    end
    if (cmd_i.out_load) begin
      out_re_q  <= res_re_q;
      out_im_q  <= res_im_q;
      out_bad_q <= bad_q;
    end
  end

  always_comb begin
    st_o.op_fetch  = (op_q == OP_FETCH);
    st_o.need_sqrt = need_sqrt;
    st_o.do_div    = do_div;
    st_o.root_zero = (root_q == '0);
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_real_o    = out_re_q;
  assign out_imag_o    = out_im_q;
  assign bad_divisor_o = out_bad_q;

endmodule

`default_nettype wire

[hdl/svn_ctrl.sv]
`default_nettype none

module svn_ctrl #(
  parameter int SQRT_STEPS = 47,
  parameter int DIV_STEPS  = 62
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire svn_pkg::status_t st_i,
  output      svn_pkg::cmd_t    cmd_o
);

  import svn_pkg::*;

  localparam int CNT_MAX = ((SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS) + 1;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADDR, S_LD, S_RD, S_DEC, S_SQRT, S_SQEND, S_DIVR, S_DIVI, S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.capture   = in_valid_i;
      S_ADDR:  cmd_o.addr_calc = 1'b1;
      S_LD:    cmd_o.load_write = 1'b1;
      S_RD:    cmd_o = '0;
      S_DEC:   cmd_o.decide    = 1'b1;
      S_SQRT:  cmd_o.sqrt_step = 1'b1;
      S_SQEND: cmd_o.sqrt_end  = 1'b1;
      S_DIVR, S_DIVI: begin
        cmd_o.div_sel_im = (state_q == S_DIVI);
        priority if (cnt_q == '0) begin
          cmd_o.div_init = 1'b1;
        end else if (cnt_q <= CNT_W'(DIV_STEPS)) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.div_save = 1'b1;
        end
      end
      S_FIN:   cmd_o.out_load  = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_ADDR;
        S_ADDR: state_q <= st_i.op_fetch ? S_RD : S_LD;
        S_LD:   state_q <= S_IDLE;
        S_RD:   state_q <= S_DEC;
        S_DEC: begin
          cnt_q <= '0;
          priority if (st_i.need_sqrt) state_q <= S_SQRT;
          else if (st_i.do_div)        state_q <= S_DIVR;
          else                         state_q <= S_FIN;
        end
        S_SQRT: begin
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_SQEND;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQEND: state_q <= st_i.root_zero ? S_FIN : S_DIVR;
        S_DIVR, S_DIVI: begin
          if (cnt_q > CNT_W'(DIV_STEPS)) begin
            cnt_q   <= '0;
            state_q <= (state_q == S_DIVR) ? S_DIVI : S_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FIN:  if (st_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_capture_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_ADDR) else $error("capture did not start");
  a_sqend_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQEND |-> $past(state_q) == S_SQRT) else $error("bad root end");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && st_i.out_free) |=> state_q == S_IDLE)
    else $error("result not handed off");
`endif

endmodule

`default_nettype wire
